FILE: rtl/bdrd_pkg.sv
// ============================================================================
// bdrd_pkg
// Shared types and constants of the block dirty-region detector: the input
// and result item layouts, register map, register reset values and an absolute-difference helper.
// ============================================================================
`default_nettype none

package bdrd_pkg;

    // Field widths fixed by the item formats, bus widths and the register index width
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = 10;
    localparam int THR_W   = 10;
    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 5;
    localparam int IDX_W   = 3;

    // Register indexes (byte address is 4 * index)
    typedef enum logic [IDX_W-1:0] {
        REG_DIFF_THRESHOLD = 3'd0,
        REG_FRAME_WIDTH    = 3'd1,
        REG_FRAME_HEIGHT   = 3'd2,
        REG_PRIOR_WIDTH    = 3'd3,
        REG_PRIOR_HEIGHT   = 3'd4
    } reg_idx_t;

    // Register reset values
    localparam logic [THR_W-1:0] RST_DIFF_THRESHOLD = 10'd16;
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH    = 13'd1920;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT   = 13'd1080;
    localparam logic [DIM_W-1:0] RST_PRIOR_WIDTH    = 13'd1920;
    localparam logic [DIM_W-1:0] RST_PRIOR_HEIGHT   = 13'd1080;

    typedef struct packed {
        logic [CHAN_W-1:0] curr_red;
        logic [CHAN_W-1:0] curr_green;
        logic [CHAN_W-1:0] curr_blue;
        logic [CHAN_W-1:0] prev_red;
        logic [CHAN_W-1:0] prev_green;
        logic [CHAN_W-1:0] prev_blue;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] rect_x;
        logic [POS_W-1:0] rect_y;
        logic [DIM_W-1:0] rect_w;
        logic [DIM_W-1:0] rect_h;
        logic             is_dirty;
        logic             frame_end;
    } out_item_t;

    // Absolute difference of two color bytes
    function automatic logic [CHAN_W-1:0] abs_diff(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bdrd_ram.sv
// ============================================================================
// bdrd_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data. A read and a write to the same address in the same cycle return the
// old contents.
// ============================================================================
`default_nettype none

module bdrd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [AW-1:0]          raddr,
    output logic      [WIDTH-1:0]       rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/block_dirty_region_detector_top.sv
// ============================================================================
// block_dirty_region_detector_top
// Frame-difference change detection over square pixel blocks. Per-column
// dirty flags live in a one-bit RAM that is read, updated and written back
// for every pixel item.
// ============================================================================
// Pipeline: an accepted item passes the address/compare stage, then the flag
//   RAM read-modify-write stage, and its result enters the output buffer.
// Throughput: one pixel item per cycle while the output buffer has room; the
//   flag RAM has one read and one write port, and back-to-back pixels of one block column are forwarded.
// Reset: registers return to their reset values, position goes to (0, 0) and
//   a valid bit per block column marks every flag clear at once.
// ============================================================================
`default_nettype none

module block_dirty_region_detector_top #(
    parameter int BLOCK_SIZE = 16,
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // pixel items
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire bdrd_pkg::in_item_t                in_item,
    // result items
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output bdrd_pkg::out_item_t                    out_item,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bdrd_pkg::APB_AW-1:0]       paddr,
    input  wire logic [bdrd_pkg::APB_DW-1:0]       pwdata,
    output logic      [bdrd_pkg::APB_DW-1:0]       prdata,
    output logic                                   pready
);

    localparam int NUM_COLS = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BXW      = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int SW       = $clog2(BLOCK_SIZE);

    localparam logic [SW-1:0] SUB_LAST = SW'(BLOCK_SIZE - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [bdrd_pkg::THR_W-1:0] diff_threshold_reg;
    logic [bdrd_pkg::DIM_W-1:0] frame_width_reg;
    logic [bdrd_pkg::DIM_W-1:0] frame_height_reg;
    logic [bdrd_pkg::DIM_W-1:0] prior_width_reg;
    logic [bdrd_pkg::DIM_W-1:0] prior_height_reg;
    logic [bdrd_pkg::IDX_W-1:0] cfg_idx;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[bdrd_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_threshold_reg <= bdrd_pkg::RST_DIFF_THRESHOLD;
            frame_width_reg    <= bdrd_pkg::RST_FRAME_WIDTH;
            frame_height_reg   <= bdrd_pkg::RST_FRAME_HEIGHT;
            prior_width_reg    <= bdrd_pkg::RST_PRIOR_WIDTH;
            prior_height_reg   <= bdrd_pkg::RST_PRIOR_HEIGHT;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                bdrd_pkg::REG_DIFF_THRESHOLD:
                    diff_threshold_reg <= pwdata[bdrd_pkg::THR_W-1:0];
                bdrd_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= pwdata[bdrd_pkg::DIM_W-1:0];
                bdrd_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= pwdata[bdrd_pkg::DIM_W-1:0];
                bdrd_pkg::REG_PRIOR_WIDTH:
                    prior_width_reg <= pwdata[bdrd_pkg::DIM_W-1:0];
                bdrd_pkg::REG_PRIOR_HEIGHT:
                    prior_height_reg <= pwdata[bdrd_pkg::DIM_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (cfg_idx)
            bdrd_pkg::REG_DIFF_THRESHOLD:
                prdata = bdrd_pkg::APB_DW'(diff_threshold_reg);
            bdrd_pkg::REG_FRAME_WIDTH:
                prdata = bdrd_pkg::APB_DW'(frame_width_reg);
            bdrd_pkg::REG_FRAME_HEIGHT:
                prdata = bdrd_pkg::APB_DW'(frame_height_reg);
            bdrd_pkg::REG_PRIOR_WIDTH:
                prdata = bdrd_pkg::APB_DW'(prior_width_reg);
            bdrd_pkg::REG_PRIOR_HEIGHT:
                prdata = bdrd_pkg::APB_DW'(prior_height_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 0: position tracking, pixel difference, flag RAM read
    // ------------------------------------------------------------------
    logic [CW-1:0]  col_reg,    col_next;
    logic [RW-1:0]  row_reg,    row_next;
    logic [SW-1:0]  sub_col_reg, sub_col_next;
    logic [SW-1:0]  sub_row_reg, sub_row_next;
    logic [BXW-1:0] bx_reg,     bx_next;
    logic [CW-1:0]  blk_x_reg,  blk_x_next;
    logic [RW-1:0]  band_y_reg, band_y_next;

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic           mismatch;
    logic           line_end;
    logic           frame_last;
    logic           blk_col_end;
    logic           blk_row_end;
    logic           row_last;
    logic [bdrd_pkg::SUM_W-1:0] diff_sum;
    logic           hit;
    logic           accept;

    assign accept = in_valid && in_ready;

    // Clamp the frame size: zero counts as one, oversize saturates
    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WW'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = HW'(1);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(frame_height_reg);
    end

    assign mismatch    = (frame_width_reg != prior_width_reg) ||
                         (frame_height_reg != prior_height_reg);
    assign line_end    = WW'(col_reg) >= (w_eff - WW'(1));
    assign row_last    = HW'(row_reg) >= (h_eff - HW'(1));
    assign frame_last  = line_end && row_last;
    assign blk_col_end = (sub_col_reg == SUB_LAST) || line_end;
    assign blk_row_end = (sub_row_reg == SUB_LAST) || row_last;

    // Summed absolute RGB difference against the threshold
    assign diff_sum = bdrd_pkg::SUM_W'(bdrd_pkg::abs_diff(in_item.curr_red,
                                                          in_item.prev_red))
                    + bdrd_pkg::SUM_W'(bdrd_pkg::abs_diff(in_item.curr_green,
                                                          in_item.prev_green))
                    + bdrd_pkg::SUM_W'(bdrd_pkg::abs_diff(in_item.curr_blue,
                                                          in_item.prev_blue));
    assign hit = !mismatch && (diff_sum > diff_threshold_reg);

    // Advance the raster position
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        bx_next      = bx_reg;
        blk_x_next   = blk_x_reg;
        band_y_next  = band_y_reg;
        if (accept)
        begin
            if (frame_last)
            begin
                col_next     = '0;
                row_next     = '0;
                sub_col_next = '0;
                sub_row_next = '0;
                bx_next      = '0;
                blk_x_next   = '0;
                band_y_next  = '0;
            end
            else if (line_end)
            begin
                col_next     = '0;
                sub_col_next = '0;
                bx_next      = '0;
                blk_x_next   = '0;
                row_next     = row_reg + RW'(1);
                if (sub_row_reg == SUB_LAST)
                begin
                    sub_row_next = '0;
                    band_y_next  = band_y_reg + RW'(BLOCK_SIZE);
                end
                else
                begin
                    sub_row_next = sub_row_reg + SW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
                if (sub_col_reg == SUB_LAST)
                begin
                    sub_col_next = '0;
                    bx_next      = bx_reg + BXW'(1);
                    blk_x_next   = blk_x_reg + CW'(BLOCK_SIZE);
                end
                else
                begin
                    sub_col_next = sub_col_reg + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            bx_reg      <= '0;
            blk_x_reg   <= '0;
            band_y_reg  <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            bx_reg      <= bx_next;
            blk_x_reg   <= blk_x_next;
            band_y_reg  <= band_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: flag read-modify-write and result build
    // ------------------------------------------------------------------
    logic                       s1_valid_reg;
    logic [BXW-1:0]             s1_bx_reg;
    logic [bdrd_pkg::POS_W-1:0] s1_x_reg;
    logic [bdrd_pkg::POS_W-1:0] s1_y_reg;
    logic [bdrd_pkg::DIM_W-1:0] s1_w_reg;
    logic [bdrd_pkg::DIM_W-1:0] s1_h_reg;
    logic                       s1_hit_reg;
    logic                       s1_blk_end_reg;
    logic                       s1_frame_last_reg;
    logic                       s1_mismatch_reg;
    logic                       s1_fwd_reg;
    logic                       s1_fwd_data_reg;

    logic [NUM_COLS-1:0]        col_valid_reg;
    logic [0:0]                 ram_rdata;
    logic                       old_flag;
    logic                       dirty;
    logic                       flag_wr;
    logic                       produce;
    bdrd_pkg::out_item_t        result;

    assign old_flag = col_valid_reg[s1_bx_reg] &&
                      (s1_fwd_reg ? s1_fwd_data_reg : ram_rdata[0]);
    assign dirty    = old_flag || s1_hit_reg;
    // Clear the flag when its block completes
    assign flag_wr  = s1_blk_end_reg ? 1'b0 : dirty;
    assign produce  = s1_valid_reg &&
                      (s1_mismatch_reg ? s1_frame_last_reg
                                       : (s1_blk_end_reg && (dirty || s1_frame_last_reg)));

    always_comb
    begin
        if (s1_mismatch_reg)
        begin
            result.rect_x    = '0;
            result.rect_y    = '0;
            result.rect_w    = s1_w_reg;
            result.rect_h    = s1_h_reg;
            result.is_dirty  = 1'b1;
            result.frame_end = 1'b1;
        end
        else
        begin
            result.rect_x    = s1_x_reg;
            result.rect_y    = s1_y_reg;
            result.rect_w    = bdrd_pkg::DIM_W'(BLOCK_SIZE);
            result.rect_h    = bdrd_pkg::DIM_W'(BLOCK_SIZE);
            result.is_dirty  = dirty;
            result.frame_end = s1_frame_last_reg;
        end
    end

    bdrd_ram #(
        .WIDTH (1),
        .DEPTH (NUM_COLS)
    ) u_flag_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_bx_reg),
        .wdata (flag_wr),
        .re    (accept),
        .raddr (bx_reg),
        .rdata (ram_rdata)
    );

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // Capture stage 1 payload; forward the write that lands with this read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bx_reg         <= bx_reg;
            s1_x_reg          <= bdrd_pkg::POS_W'(blk_x_reg);
            s1_y_reg          <= bdrd_pkg::POS_W'(band_y_reg);
            s1_w_reg          <= bdrd_pkg::DIM_W'(w_eff);
            s1_h_reg          <= bdrd_pkg::DIM_W'(h_eff);
            s1_hit_reg        <= hit;
            s1_blk_end_reg    <= blk_col_end && blk_row_end;
            s1_frame_last_reg <= frame_last;
            s1_mismatch_reg   <= mismatch;
            s1_fwd_reg        <= s1_valid_reg && (s1_bx_reg == bx_reg);
            s1_fwd_data_reg   <= flag_wr;
        end
    end

    // Valid bit per column: set on write, drop all at frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_valid_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_frame_last_reg)
            begin
                col_valid_reg <= '0;
            end
            else
            begin
                col_valid_reg[s1_bx_reg] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: two entries
    // ------------------------------------------------------------------
    bdrd_pkg::out_item_t ob_mem_reg [2];
    logic                ob_wr_reg;
    logic                ob_rd_reg;
    logic [1:0]          ob_count_reg;
    logic [1:0]          ob_count_next;
    logic                ob_push;
    logic                ob_pop;
    logic                s1_pending;

    assign ob_push    = produce;
    assign ob_pop     = out_valid && out_ready;
    assign out_valid  = (ob_count_reg != 2'd0);
    assign out_item   = ob_mem_reg[ob_rd_reg];
    assign s1_pending = s1_valid_reg && s1_blk_end_reg;

    // Take an item only when its possible result is sure to fit
    assign in_ready = (3'(ob_count_reg) + 3'(s1_pending)) < (3'd2 + 3'(ob_pop));

    assign ob_count_next = ob_count_reg + 2'(ob_push) - 2'(ob_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_reg    <= 1'b0;
            ob_rd_reg    <= 1'b0;
            ob_count_reg <= 2'd0;
        end
        else
        begin
            ob_count_reg <= ob_count_next;
            if (ob_push)
            begin
                ob_wr_reg <= ~ob_wr_reg;
            end
            if (ob_pop)
            begin
                ob_rd_reg <= ~ob_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_push)
        begin
            ob_mem_reg[ob_wr_reg] <= result;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ob_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ob_push |-> (ob_count_reg != 2'd2) || ob_pop)
        else $error("output buffer overflow");

    a_ob_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ob_count_reg != 2'd3)
        else $error("output buffer count out of range");

    a_s1_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("stage 1 lost an accepted item");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_last |=> (col_reg == '0) && (row_reg == '0) &&
                                 (bx_reg == '0) && (band_y_reg == '0))
        else $error("position did not return to origin at frame end");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Block dirty-region detector testbench
// Streams pixel pairs through the detector under a range of frame sizes and
// thresholds, predicts every rectangle item from a behavioral copy of the
// block, and checks each result item field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdrd_pkg::*;

    localparam int BLK           = 16;
    localparam int MAXDIM        = 4096;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 2000;

    // Behavioral copy of the detector and the queue of rectangles it predicts
    class rect_scoreboard;
        logic [THR_W-1:0] threshold;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        logic [DIM_W-1:0] prior_w_reg;
        logic [DIM_W-1:0] prior_h_reg;
        bit               col_dirty [MAXDIM/BLK];
        int unsigned      col;
        int unsigned      row;
        out_item_t        expected_rects [$];
        bit               frame_done;
        int               errors;

        function new();
            threshold   = RST_DIFF_THRESHOLD;
            width_reg   = RST_FRAME_WIDTH;
            height_reg  = RST_FRAME_HEIGHT;
            prior_w_reg = RST_PRIOR_WIDTH;
            prior_h_reg = RST_PRIOR_HEIGHT;
            foreach (col_dirty[i]) col_dirty[i] = 1'b0;
            col        = 0;
            row        = 0;
            frame_done = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_DIFF_THRESHOLD: threshold   = value[THR_W-1:0];
                REG_FRAME_WIDTH:    width_reg   = value[DIM_W-1:0];
                REG_FRAME_HEIGHT:   height_reg  = value[DIM_W-1:0];
                REG_PRIOR_WIDTH:    prior_w_reg = value[DIM_W-1:0];
                REG_PRIOR_HEIGHT:   prior_h_reg = value[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Treat zero as one and saturate at the largest frame size
        function int unsigned clamp_dim(logic [DIM_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAXDIM) return MAXDIM;
            return v;
        endfunction

        function int unsigned channel_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
            return (a > b) ? (a - b) : (b - a);
        endfunction

        // Predict any rectangle for one accepted pixel item and advance the raster position
        function void note_pixel(in_item_t px);
            int unsigned w;
            int unsigned h;
            int unsigned bx;
            int unsigned sum;
            bit          mismatch;
            bit          line_end;
            bit          last;
            bit          block_done;
            bit          dirty;
            out_item_t   r;
            w        = clamp_dim(width_reg);
            h        = clamp_dim(height_reg);
            mismatch = (width_reg != prior_w_reg) || (height_reg != prior_h_reg);
            bx       = col / BLK;
            line_end = col >= w - 1;
            last     = line_end && (row >= h - 1);
            block_done = ((col % BLK == BLK - 1) || line_end) &&
                         ((row % BLK == BLK - 1) || (row >= h - 1));
            sum = channel_diff(px.curr_red, px.prev_red) +
                  channel_diff(px.curr_green, px.prev_green) +
                  channel_diff(px.curr_blue, px.prev_blue);
            if (!mismatch && sum > threshold) col_dirty[bx] = 1'b1;
            dirty = col_dirty[bx];

            if (mismatch) begin
                // pixel data is ignored; one full-frame rectangle at the end
                if (last) begin
                    r.rect_x    = '0;
                    r.rect_y    = '0;
                    r.rect_w    = DIM_W'(w);
                    r.rect_h    = DIM_W'(h);
                    r.is_dirty  = 1'b1;
                    r.frame_end = 1'b1;
                    expected_rects.push_back(r);
                end
            end else if (block_done && (dirty || last)) begin
                r.rect_x    = POS_W'(bx * BLK);
                r.rect_y    = POS_W'(row - row % BLK);
                r.rect_w    = DIM_W'(BLK);
                r.rect_h    = DIM_W'(BLK);
                r.is_dirty  = dirty;
                r.frame_end = last;
                expected_rects.push_back(r);
            end
            if (block_done) col_dirty[bx] = 1'b0;

            // wrap the position at line and frame ends
            if (last) begin
                foreach (col_dirty[i]) col_dirty[i] = 1'b0;
                col = 0;
                row = 0;
            end else if (line_end) begin
                col = 0;
                row = row + 1;
            end else begin
                col = col + 1;
            end
            frame_done = last;
        endfunction

        function void compare_field(string name, logic [DIM_W-1:0] want,
                                    logic [DIM_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        // Match an accepted rectangle item against the oldest prediction
        function void check_rect(out_item_t got);
            out_item_t want;
            if (expected_rects.size() == 0) begin
                errors++;
                $display("%0t: unexpected rectangle, expected none, actual x=%0d y=%0d w=%0d h=%0d dirty=%0b end=%0b",
                         $time, got.rect_x, got.rect_y, got.rect_w, got.rect_h,
                         got.is_dirty, got.frame_end);
                return;
            end
            want = expected_rects.pop_front();
            compare_field("rect_x", want.rect_x, got.rect_x);
            compare_field("rect_y", want.rect_y, got.rect_y);
            compare_field("rect_w", want.rect_w, got.rect_w);
            compare_field("rect_h", want.rect_h, got.rect_h);
            compare_field("is_dirty", want.is_dirty, got.is_dirty);
            compare_field("frame_end", want.frame_end, got.frame_end);
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_item_t          in_item   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_item;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    rect_scoreboard sb = new();
    bit             quiet      = 1'b0;
    bit             hold_start = 1'b0;
    int             hold_left  = 0;
    int unsigned    pixel_count = 0;

    block_dirty_region_detector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Check result items, stall at random, and hold off on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_rect(out_item);
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= quiet || ($urandom_range(99) >= 22);
        end
    end

    // Offer one pixel item, with an occasional gap, and hold it until taken
    task automatic send_pixel(in_item_t px);
        if (!quiet && $urandom_range(99) < 22) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pixel(px);
        pixel_count++;
    endtask

    // Drop valid and let every predicted rectangle come out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_rects.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [DIM_W-1:0] value);
        logic [APB_DW-1:0] data;
        data = $urandom_range(1) ? $urandom : '0;
        data[DIM_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_frame(logic [DIM_W-1:0] fw, logic [DIM_W-1:0] fh,
                             logic [DIM_W-1:0] pw, logic [DIM_W-1:0] ph,
                             logic [DIM_W-1:0] thr);
        drain();
        apb_write(REG_FRAME_WIDTH, fw);
        apb_write(REG_FRAME_HEIGHT, fh);
        apb_write(REG_PRIOR_WIDTH, pw);
        apb_write(REG_PRIOR_HEIGHT, ph);
        apb_write(REG_DIFF_THRESHOLD, thr);
    endtask

    function automatic in_item_t pixel_of(int cr, int cg, int cb, int pr, int pg, int pb);
        in_item_t px;
        px.curr_red   = cr;
        px.curr_green = cg;
        px.curr_blue  = cb;
        px.prev_red   = pr;
        px.prev_green = pg;
        px.prev_blue  = pb;
        return px;
    endfunction

    // Unchanged pixels, near-misses and fully random changes, in shares set by dirty_pct
    function automatic in_item_t random_pixel(int unsigned dirty_pct);
        in_item_t    px;
        int unsigned r;
        px.prev_red   = $urandom_range(255);
        px.prev_green = $urandom_range(255);
        px.prev_blue  = $urandom_range(255);
        px.curr_red   = $urandom_range(255);
        px.curr_green = $urandom_range(255);
        px.curr_blue  = $urandom_range(255);
        r = $urandom_range(99);
        if (r >= dirty_pct + 10) begin
            px.curr_red   = px.prev_red;
            px.curr_green = px.prev_green;
            px.curr_blue  = px.prev_blue;
        end else if (r >= dirty_pct) begin
            px.curr_red   = px.prev_red ^ CHAN_W'($urandom_range(3));
            px.curr_green = px.prev_green ^ CHAN_W'($urandom_range(3));
            px.curr_blue  = px.prev_blue ^ CHAN_W'($urandom_range(3));
        end
        return px;
    endfunction

    // Mostly small sizes, now and then a zero or a somewhat larger one
    function automatic logic [DIM_W-1:0] pick_dim(int unsigned common_max,
                                                  int unsigned rare_max);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 75) return $urandom_range(1, common_max);
        return $urandom_range(common_max + 1, rare_max);
    endfunction

    // Run one frame of random pixels, optionally resizing it partway through
    task automatic run_frame(logic [DIM_W-1:0] fw, logic [DIM_W-1:0] fh,
                             logic [DIM_W-1:0] pw, logic [DIM_W-1:0] ph,
                             logic [DIM_W-1:0] thr, int unsigned dirty_pct,
                             bit resize_mid, bit hold);
        int unsigned      sent;
        int unsigned      change_at;
        logic [DIM_W-1:0] nw;
        logic [DIM_W-1:0] nh;
        set_frame(fw, fh, pw, ph, thr);
        if (hold) hold_start = 1'b1;
        change_at = resize_mid ? $urandom_range(1, 200) : 0;
        sent = 0;
        do begin
            send_pixel(random_pixel(dirty_pct));
            sent++;
            if (sent == change_at && !sb.frame_done) begin
                nw = pick_dim(20, 48);
                nh = pick_dim(17, 36);
                drain();
                apb_write(REG_FRAME_WIDTH, nw);
                apb_write(REG_FRAME_HEIGHT, nh);
                apb_write(REG_PRIOR_WIDTH, ($urandom_range(99) < 80) ? nw : nw + 1);
                apb_write(REG_PRIOR_HEIGHT, nh);
            end
        end while (!sb.frame_done);
    endtask

    initial
    begin : stimulus
        int unsigned      start;
        int unsigned      done_pixels;
        logic [DIM_W-1:0] fw;
        logic [DIM_W-1:0] fh;
        logic [DIM_W-1:0] pw;
        logic [DIM_W-1:0] ph;
        logic [DIM_W-1:0] thr;
        int unsigned      dirty_pct;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-pixel frames: two clean markers, then one changed channel at a time
        set_frame(1, 1, 1, 1, 0);
        send_pixel(pixel_of(0, 0, 0, 0, 0, 0));
        send_pixel(pixel_of(255, 255, 255, 255, 255, 255));
        send_pixel(pixel_of(1, 0, 0, 0, 0, 0));
        send_pixel(pixel_of(0, 0, 0, 0, 200, 0));
        send_pixel(pixel_of(0, 0, 255, 0, 0, 0));
        // largest possible difference right at and just over the threshold
        set_frame(1, 1, 1, 1, 765);
        send_pixel(pixel_of(255, 255, 255, 0, 0, 0));
        send_pixel(pixel_of(0, 0, 0, 255, 255, 255));
        set_frame(1, 1, 1, 1, 764);
        send_pixel(pixel_of(255, 255, 255, 0, 0, 0));
        // size mismatch with a zero width, then a two-pixel mismatch frame
        set_frame(0, 1, 1, 1, 16);
        send_pixel(pixel_of(9, 9, 9, 200, 200, 200));
        set_frame(1, 2, 1, 1, 16);
        send_pixel(pixel_of(9, 9, 9, 200, 200, 200));
        send_pixel(pixel_of(9, 9, 9, 200, 200, 200));
        // clean full block gives nothing; the cut-off final block is dirty
        set_frame(17, 1, 17, 1, 16);
        repeat (16) send_pixel(pixel_of(50, 60, 70, 50, 60, 70));
        send_pixel(pixel_of(50, 60, 70, 0, 60, 70));

        // saturated sizes: widest line, tallest column, full-size mismatch
        run_frame(8191, 0, 8191, 0, 30, 5, 1'b0, 1'b0);
        run_frame(1, 8191, 1, 8191, 30, 5, 1'b0, 1'b0);
        run_frame(8191, 1, 4096, 1, 30, 5, 1'b0, 1'b0);

        // back up the result path while every block is dirty
        run_frame(256, 1, 256, 1, 0, 100, 1'b0, 1'b1);

        // random frames, with a quiet stretch in the middle
        start = pixel_count;
        done_pixels = 0;
        while (done_pixels < RANDOM_PIXELS) begin
            quiet = (done_pixels >= 700) && (done_pixels < 1100);
            fw = pick_dim(20, 48);
            fh = pick_dim(17, 36);
            pw = fw;
            ph = fh;
            if ($urandom_range(99) >= 85) begin
                if ($urandom_range(1)) pw = pick_dim(20, 48);
                else ph = pick_dim(17, 36);
            end
            case ($urandom_range(5))
                0:       thr = 0;
                1:       thr = 765;
                2:       thr = 1023;
                3:       thr = $urandom_range(20);
                default: thr = $urandom_range(765);
            endcase
            case ($urandom_range(4))
                0:       dirty_pct = 0;
                1:       dirty_pct = 1;
                2:       dirty_pct = 5;
                3:       dirty_pct = 20;
                default: dirty_pct = 100;
            endcase
            run_frame(fw, fh, pw, ph, thr, dirty_pct, $urandom_range(9) == 0, 1'b0);
            done_pixels = pixel_count - start;
        end
        quiet = 1'b0;

        // let the last rectangles out, then settle
        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_rects.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/bdrd_pkg.sv
rtl/bdrd_ram.sv
rtl/block_dirty_region_detector_top.sv
tb/tb.sv
